FILE: design/cps_pkg.sv
`default_nettype none
package cps_pkg;

    localparam int MaxFrames = 7;
    localparam int IdTableLen = 7;

    localparam int FifoDepth = 4;
    localparam int PtrW = $clog2(FifoDepth);
    localparam int CountW = $clog2(FifoDepth + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [28:0] frame_id;
        logic [63:0] frame_data;
        logic        last_frame;
        logic        overflow;
    } t_out_word;

    // up to two result words pushed in one cycle, word0 first
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    function automatic logic [28:0] cps_frame_id(input logic [2:0] idx);
        logic [31:0] id;
        case (idx)
            3'd0:    id = 32'h140B7FFF;
            3'd1:    id = 32'h142B7FFF;
            3'd2:    id = 32'h144B7FFF;
            3'd3:    id = 32'h146B7FFF;
            3'd4:    id = 32'h148B7FFF;
            3'd5:    id = 32'h14CB7FFF;
            default: id = 32'h14EB7FFF;
        endcase
        return id[28:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/cps_frame_fifo.sv
`default_nettype none
module cps_frame_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cps_pkg::t_push     i_push,
    input  wire cps_pkg::t_out_word i_word0,
    input  wire cps_pkg::t_out_word i_word1,
    output logic                    o_room2,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output cps_pkg::t_out_word      o_word
);
    import cps_pkg::*;

    t_out_word r_mem [FifoDepth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CountW-1:0] r_count, n_count;
    logic [PtrW-1:0]   wr_ptr1;
    logic              pop;
    logic [1:0]        push_n;

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= CountW'(FifoDepth - 2));
    assign pop     = o_valid && !i_stall;
    assign wr_ptr1 = r_wr_ptr + PtrW'(1);

    always_comb begin
        push_n  = {1'b0, i_push.push0} + {1'b0, i_push.push1};
        n_count = r_count + CountW'(push_n) - CountW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PtrW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_word0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr1] <= i_word1;
        end
    end

endmodule
`default_nettype wire

FILE: design/can_payload_segmenter_checksum_top.sv
`default_nettype none
// CAN payload segmenter with 8-bit additive checksum.
// Input channel: one payload byte per word (i_in_word), last_byte on the final
// byte. Output channel: one CAN frame per word (o_out_word): 29-bit extended
// id from the id table in frame order, eight data bytes (first in bits 7:0),
// last_frame on the frame that carries the checksum, overflow on every frame
// after the first MaxFrames frames of the payload.
// The byte is packed and summed in the cycle it is accepted; the frames it
// completes are written to a 4-word output queue at the accepting edge, so
// o_out_valid is high in the next cycle. Throughput is one byte per cycle
// while o_in_stall is low; a byte that ends a full last frame yields two
// frames, drained one per cycle while i_out_stall is low.
// o_in_stall is high while the output queue holds more than two words, so a
// byte is accepted only when both of its possible frames fit. A stalled output
// holds its word until taken; bytes keep being accepted while queue room lasts.
// Reset (synchronous, active low) empties the queue and clears the partial
// frame, byte count, frame index and running sum. After the final byte of a
// payload the same state returns to its reset values.
module can_payload_segmenter_checksum_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire cps_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output cps_pkg::t_out_word      o_out_word
);
    import cps_pkg::*;

    localparam logic [2:0] LastIdx = 3'(MaxFrames - 1);

    logic [63:0] r_frame_bytes, n_frame_bytes;
    logic [2:0]  r_byte_count, n_byte_count;
    logic [2:0]  r_frame_index, n_frame_index;
    logic [7:0]  r_running_sum, n_running_sum;
    logic        r_index_over, n_index_over;

    logic        room2, accept, full;
    logic [7:0]  sum_acc;
    logic [63:0] bytes_acc, ck_data;
    logic [2:0]  idx_a, idx_b;
    logic        over_b;
    t_push       push;
    t_out_word   word0, word1, word_full, word_last;

    assign o_in_stall = !room2;
    assign accept     = i_in_valid && room2;

    always_comb begin
        sum_acc   = r_running_sum + i_in_word.data_byte;
        bytes_acc = r_frame_bytes;
        bytes_acc[{r_byte_count, 3'b000} +: 8] = i_in_word.data_byte;
        full = (r_byte_count == 3'd7);

        idx_a = (r_frame_index > LastIdx) ? LastIdx : r_frame_index;
        // index and overflow after the full frame, if there is one
        if (full && (r_index_over || r_frame_index >= LastIdx)) begin
            idx_b  = LastIdx;
            over_b = 1'b1;
        end else if (full) begin
            idx_b  = r_frame_index + 3'd1;
            over_b = r_index_over;
        end else begin
            idx_b  = r_frame_index;
            over_b = r_index_over;
        end

        word_full.frame_id   = cps_frame_id(idx_a);
        word_full.frame_data = bytes_acc;
        word_full.last_frame = 1'b0;
        word_full.overflow   = r_index_over;

        ck_data = full ? 64'd0 : bytes_acc;
        if (!full) begin
            ck_data[{r_byte_count + 3'd1, 3'b000} +: 8] = sum_acc;
        end else begin
            ck_data[7:0] = sum_acc;
        end
        word_last.frame_id   = cps_frame_id((idx_b > LastIdx) ? LastIdx : idx_b);
        word_last.frame_data = ck_data;
        word_last.last_frame = 1'b1;
        word_last.overflow   = over_b;

        push.push0 = accept && (full || i_in_word.last_byte);
        push.push1 = accept && full && i_in_word.last_byte;
        word0 = full ? word_full : word_last;
        word1 = word_last;

        n_frame_bytes = r_frame_bytes;
        n_byte_count  = r_byte_count;
        n_frame_index = r_frame_index;
        n_running_sum = r_running_sum;
        n_index_over  = r_index_over;
        if (accept) begin
            if (i_in_word.last_byte) begin
                n_frame_bytes = '0;
                n_byte_count  = '0;
                n_frame_index = '0;
                n_running_sum = '0;
                n_index_over  = 1'b0;
            end else begin
                n_frame_bytes = full ? 64'd0 : bytes_acc;
                n_byte_count  = r_byte_count + 3'd1;
                n_frame_index = idx_b;
                n_running_sum = sum_acc;
                n_index_over  = over_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= '0;
            r_byte_count  <= '0;
            r_frame_index <= '0;
            r_running_sum <= '0;
            r_index_over  <= 1'b0;
        end else begin
            r_frame_bytes <= n_frame_bytes;
            r_byte_count  <= n_byte_count;
            r_frame_index <= n_frame_index;
            r_running_sum <= n_running_sum;
            r_index_over  <= n_index_over;
        end
    end

    cps_frame_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word0 (word0),
        .i_word1 (word1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule
`default_nettype wire
